// ===== sv/nnact_pkg.sv =====
// Shared constants, types and the sigmoid breakpoint table of the activation unit.
package nnact_pkg;

  localparam int unsigned DATA_WIDTH     = 16;
  localparam int unsigned FRAC_BITS      = 8;
  localparam int unsigned TABLE_SEGMENTS = 64;

  localparam int unsigned MODE_W     = 3;
  localparam int unsigned SLOPE_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Sigmoid table entries are unsigned Q0.24.
  localparam int unsigned Q_BITS   = 24;
  localparam int unsigned TAB_W    = Q_BITS + 1;
  localparam int unsigned TAB_BITS = (TABLE_SEGMENTS + 1) * TAB_W;
  localparam int unsigned SEG_W    = $clog2(TABLE_SEGMENTS);
  localparam int unsigned SPAN_LOG = FRAC_BITS + 4;
  localparam int unsigned RND_SH   = Q_BITS - FRAC_BITS;
  localparam int unsigned SIG_OFFSET = 8 << FRAC_BITS;

  localparam logic [63:0] EXP_NEG_ONE_Q32 = 64'h0000_0000_5E2D_58D9;

  typedef enum logic [MODE_W-1:0] {
    MODE_TANH    = MODE_W'(0),
    MODE_RELU    = MODE_W'(1),
    MODE_SIGMOID = MODE_W'(2),
    MODE_LINEAR  = MODE_W'(3),
    MODE_LEAKY   = MODE_W'(4)
  } act_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = CFG_IDX_W'(0),
    REG_LEAK_SLOPE = CFG_IDX_W'(1)
  } cfg_reg_e;

  localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_RELU;
  localparam logic [SLOPE_W-1:0] SLOPE_RESET = SLOPE_W'(13107);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] y;
    logic                  last;
  } out_item_t;

  // Shift-subtract division, used only while building the table at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid at breakpoint k of [-8,8], Q0.24, via a Q32 series for exp(-|p|)
  function automatic logic [TAB_W-1:0] sig_point(input int k);
    logic [63:0] segs, ad, a, q, rem, f, term, sum, v, num, den, res;
    logic        neg;
    segs = 64'(TABLE_SEGMENTS);
    neg  = (2 * k < TABLE_SEGMENTS);
    ad   = neg ? 64'(TABLE_SEGMENTS - 2 * k) : 64'(2 * k - TABLE_SEGMENTS);
    a    = ad << 3;
    q    = udiv64(a, segs);
    rem  = a - q * segs;
    f    = udiv64(rem << 32, segs);
    term = 64'd1 << 32;
    sum  = term;
    for (int n = 1; n <= 24; n++) begin
      term = udiv64((term * f) >> 32, 64'(n));
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = sum;
    for (int i = 0; 64'(i) < q; i++) begin
      v = (v * EXP_NEG_ONE_Q32 + (64'd1 << 31)) >> 32;
    end
    den = (64'd1 << 32) + v;
    num = neg ? v : (64'd1 << 32);
    res = udiv64((num << 24) + (den >> 1), den);
    return res[TAB_W-1:0];
  endfunction

  function automatic logic [TAB_BITS-1:0] build_sig_tab();
    logic [TAB_BITS-1:0] t;
    t = '0;
    for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
      t[k*TAB_W +: TAB_W] = sig_point(k);
    end
    return t;
  endfunction

  localparam logic [TAB_BITS-1:0] SIG_TAB = build_sig_tab();

  function automatic logic [TAB_W-1:0] sig_tab_at(input logic [SEG_W:0] idx);
    return SIG_TAB[idx*TAB_W +: TAB_W];
  endfunction

endpackage

// ===== sv/nnact_skid.sv =====
// Output skid buffer: registered result plus one spare entry, registered upstream ready.
module nnact_skid
  import nnact_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  out_item_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      out_valid_q, out_valid_d;
  logic      spare_valid_q, spare_valid_d;
  out_item_t out_item_q, out_item_d;
  out_item_t spare_item_q, spare_item_d;
  logic      in_fire, out_free;

  assign in_ready_o = !spare_valid_q;
  assign in_fire    = in_valid_i && !spare_valid_q;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d   = out_valid_q;
    spare_valid_d = spare_valid_q;
    out_item_d    = out_item_q;
    spare_item_d  = spare_item_q;
    if (out_free) begin
      if (spare_valid_q) begin
        out_valid_d   = 1'b1;
        out_item_d    = spare_item_q;
        spare_valid_d = 1'b0;
      end else if (in_fire) begin
        out_valid_d = 1'b1;
        out_item_d  = in_item_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      // output held: park the transaction in the spare entry
      spare_valid_d = 1'b1;
      spare_item_d  = in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      spare_valid_q <= 1'b0;
    end else begin
      out_valid_q   <= out_valid_d;
      spare_valid_q <= spare_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q   <= out_item_d;
    spare_item_q <= spare_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== sv/nn_activation_unit.sv =====
// Top level of the streaming neural-network activation unit.
//
// Element-wise activation for Q8.8 layer vectors. Each slave transaction carries
// one signed activation in s_axis_tdata and an end-of-vector flag in
// s_axis_tlast; each master transaction returns the activated, saturated value
// and the copied flag, in order. Register 0 (mode) selects the function:
// 0 tanh, 1 relu, 2 sigmoid, 3 linear, 4 leaky relu; other codes give zero.
// Register 1 is the unsigned Q0.16 negative slope of leaky relu. Sigmoid uses
// linear interpolation over a 64-segment constant table on [-8,8) and clamps to
// the end values outside it; tanh is 2*sigmoid(2x)-1 on the same table.
// Write the registers only while no transaction is in flight. The unit takes
// one transaction every cycle: a three-stage pipeline (range and index, table
// lookup and slope multiply, interpolation sum) feeds a two-entry output skid
// buffer, and a result reaches the master side through the stage registers
// and then the skid buffer's output register. The pipeline stalls as a whole
// only when the skid buffer's spare entry is occupied; s_axis_tready comes
// from a register and does not depend combinationally on m_axis_tready.
module nn_activation_unit
  import nnact_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DATA_WIDTH-1:0] s_axis_tdata,   // [15:0] x_in
  input  logic                  s_axis_tlast,
  // master stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DATA_WIDTH-1:0] m_axis_tdata,   // [15:0] y_out
  output logic                  m_axis_tlast,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned U_W    = DATA_WIDTH + 2;
  localparam int unsigned PROD_W = SPAN_LOG + SEG_W;
  localparam int unsigned LEAK_W = DATA_WIDTH + SLOPE_W + 1;
  localparam int unsigned MUL_W  = TAB_W + SPAN_LOG + 2;
  localparam int unsigned S_W    = TAB_W + 2;
  localparam int unsigned V_W    = TAB_W + 3;

  localparam logic signed [V_W-1:0] Y_MAX = V_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic signed [V_W-1:0] Y_MIN = ~Y_MAX;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [SLOPE_W-1:0] slope_q, slope_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    mode_d  = mode_q;
    slope_d = slope_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE:       mode_d  = cfg_data_i[MODE_W-1:0];
        REG_LEAK_SLOPE: slope_d = cfg_data_i[SLOPE_W-1:0];
        default:        ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RESET;
      slope_q <= SLOPE_RESET;
    end else begin
      mode_q  <= mode_d;
      slope_q <= slope_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: advance every stage together while the skid buffer can
  // take a transaction.
  // ---------------------------------------------------------------------------
  logic      adv;
  logic      v1_q, v2_q, v3_q;
  out_item_t res_item;

  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: sigmoid argument, range check, segment index and fraction;
  // leaky relu product.
  // ---------------------------------------------------------------------------
  logic signed [DATA_WIDTH-1:0] x_in;
  logic signed [DATA_WIDTH:0]   xr;
  logic signed [U_W-1:0]        u;
  logic                         sat_lo, sat_hi;
  logic [PROD_W-1:0]            seg_prod;
  logic [SEG_W-1:0]             seg_k;
  logic [SPAN_LOG-1:0]          seg_r;
  logic signed [LEAK_W-1:0]     leak_prod;

  assign x_in = $signed(s_axis_tdata);
  // tanh evaluates the table at 2x
  assign xr   = (mode_q == MODE_TANH) ? $signed({x_in, 1'b0}) : $signed({x_in[DATA_WIDTH-1], x_in});
  assign u    = $signed({xr[DATA_WIDTH], xr}) + $signed(U_W'(SIG_OFFSET));

  assign sat_lo   = u[U_W-1];
  assign sat_hi   = !sat_lo && (u[U_W-2:SPAN_LOG] != '0);
  assign seg_prod = PROD_W'(u[SPAN_LOG-1:0]) * PROD_W'(TABLE_SEGMENTS);
  assign seg_k    = seg_prod[PROD_W-1:SPAN_LOG];
  assign seg_r    = seg_prod[SPAN_LOG-1:0];

  assign leak_prod = x_in * $signed({1'b0, slope_q});

  logic [MODE_W-1:0]            mode1_q;
  logic                         last1_q, hi1_q;
  logic signed [DATA_WIDTH-1:0] x1_q;
  logic [SEG_W-1:0]             k1_q;
  logic [SPAN_LOG-1:0]          r1_q;
  logic signed [LEAK_W-1:0]     leak1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode1_q <= mode_q;
      last1_q <= s_axis_tlast;
      x1_q    <= x_in;
      hi1_q   <= sat_hi;
      leak1_q <= leak_prod;
      if (sat_lo) begin
        k1_q <= '0;
        r1_q <= '0;
      end else if (sat_hi) begin
        // point at the last segment; its right end is taken below
        k1_q <= SEG_W'(TABLE_SEGMENTS - 1);
        r1_q <= '0;
      end else begin
        k1_q <= seg_k;
        r1_q <= seg_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: table lookup and slope times fraction; piecewise-linear results.
  // ---------------------------------------------------------------------------
  logic [TAB_W-1:0]             t_k, t_k1, base;
  logic signed [TAB_W:0]        t_diff;
  logic signed [MUL_W-1:0]      interp_mul;
  logic signed [LEAK_W-1:0]     leak_sh;
  logic signed [DATA_WIDTH-1:0] direct;

  assign t_k        = sig_tab_at({1'b0, k1_q});
  assign t_k1       = sig_tab_at((SEG_W + 1)'(k1_q) + (SEG_W + 1)'(1));
  assign base       = hi1_q ? t_k1 : t_k;
  assign t_diff     = $signed({1'b0, t_k1}) - $signed({1'b0, t_k});
  assign interp_mul = t_diff * $signed({1'b0, r1_q});
  assign leak_sh    = leak1_q >>> SLOPE_W;

  always_comb begin
    unique case (mode1_q)
      MODE_RELU:   direct = (x1_q > 0) ? x1_q : '0;
      MODE_LINEAR: direct = x1_q;
      MODE_LEAKY:  direct = x1_q[DATA_WIDTH-1] ? leak_sh[DATA_WIDTH-1:0] : x1_q;
      default:     direct = '0;
    endcase
  end

  logic [MODE_W-1:0]            mode2_q;
  logic                         last2_q;
  logic [TAB_W-1:0]             base2_q;
  logic signed [MUL_W-1:0]      mul2_q;
  logic signed [DATA_WIDTH-1:0] direct2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode2_q   <= mode1_q;
      last2_q   <= last1_q;
      base2_q   <= base;
      mul2_q    <= interp_mul;
      direct2_q <= direct;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: interpolated sigmoid in Q0.24, tanh rescale.
  // ---------------------------------------------------------------------------
  logic signed [MUL_W-1:0] frac_full;
  logic signed [S_W-1:0]   sig_s;
  logic signed [V_W-1:0]   sig_v;

  // divide by the span, truncating toward zero
  assign frac_full = mul2_q[MUL_W-1]
                   ? (mul2_q + $signed(MUL_W'((64'd1 << SPAN_LOG) - 64'd1))) >>> SPAN_LOG
                   : mul2_q >>> SPAN_LOG;
  assign sig_s = $signed({2'b00, base2_q}) + frac_full[S_W-1:0];
  assign sig_v = (mode2_q == MODE_TANH)
               ? (V_W'(sig_s) <<< 1) - $signed(V_W'(64'd1 << Q_BITS))
               : V_W'(sig_s);

  logic [MODE_W-1:0]            mode3_q;
  logic                         last3_q;
  logic signed [V_W-1:0]        v3_val_q;
  logic signed [DATA_WIDTH-1:0] direct3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode3_q   <= mode2_q;
      last3_q   <= last2_q;
      v3_val_q  <= sig_v;
      direct3_q <= direct2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Round to the output fraction (half toward +inf), select, saturate; the skid
  // buffer holds the registered result.
  // ---------------------------------------------------------------------------
  logic signed [V_W-1:0] sig_y, y_sel, y_sat;

  assign sig_y = (v3_val_q + $signed(V_W'(64'd1 << (RND_SH - 1)))) >>> RND_SH;
  assign y_sel = ((mode3_q == MODE_TANH) || (mode3_q == MODE_SIGMOID))
               ? sig_y : V_W'(direct3_q);

  always_comb begin
    priority if (y_sel > Y_MAX) begin
      y_sat = Y_MAX;
    end else if (y_sel < Y_MIN) begin
      y_sat = Y_MIN;
    end else begin
      y_sat = y_sel;
    end
  end

  assign res_item.y    = y_sat[DATA_WIDTH-1:0];
  assign res_item.last = last3_q;

  out_item_t out_item;

  nnact_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v3_q),
    .in_ready_o  (adv),
    .in_item_i   (res_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = out_item.y;
  assign m_axis_tlast = out_item.last;

endmodule

// ===== tb/nnact_checker.sv =====
// Scoreboard for the activation unit: predicts each element's result and compares it.
module nnact_checker
  import nnact_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [DATA_WIDTH-1:0] s_axis_tdata,   // [15:0] x_in
  input  logic                  s_axis_tlast,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [DATA_WIDTH-1:0] m_axis_tdata,   // [15:0] y_out
  input  logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count,
  output int                    outstanding,
  output int                    checked_count
);

  localparam int unsigned SIG_Q     = 24;
  localparam longint      Q_ONE     = longint'(1) << SIG_Q;
  localparam logic [63:0] E_INV_Q32 = 64'h0000_0000_5E2D_58D9;

  longint            knot_q24 [0:TABLE_SEGMENTS];
  logic [MODE_W-1:0]  mode_q;
  logic [SLOPE_W-1:0] slope_q;
  out_item_t         due_q [$];

  // sigmoid at breakpoint k in Q0.24: exp(-|p|) from a Q32 series on the fraction,
  // scaled by e^-1 once per whole unit, then 1/(1+e) or e/(1+e)
  function automatic longint knot_value(input int k);
    longint      d;
    logic [63:0] ad, a, whole, f, term, sum, v, num, den;
    d     = longint'(2 * k) - longint'(TABLE_SEGMENTS);
    ad    = (d < 0) ? 64'(-d) : 64'(d);
    a     = ad << 3;
    whole = a / 64'(TABLE_SEGMENTS);
    f     = ((a % 64'(TABLE_SEGMENTS)) << 32) / 64'(TABLE_SEGMENTS);
    term  = 64'd1 << 32;
    sum   = term;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * f) >> 32) / 64'(n);
      sum  = (n % 2 == 1) ? sum - term : sum + term;
    end
    v = sum;
    for (longint i = 0; 64'(i) < whole; i++) begin
      v = (v * E_INV_Q32 + (64'd1 << 31)) >> 32;
    end
    den = (64'd1 << 32) + v;
    num = (d >= 0) ? (64'd1 << 32) : v;
    return longint'(((num << 24) + (den >> 1)) / den);
  endfunction

  // interpolated sigmoid in Q0.24, clamped to the end knots outside [-8,8)
  function automatic longint sigmoid_at(input longint xr);
    longint span, u, prod, k, r;
    span = longint'(16) << FRAC_BITS;
    u    = xr + (longint'(8) << FRAC_BITS);
    if (u < 0) return knot_q24[0];
    if (u >= span) return knot_q24[TABLE_SEGMENTS];
    prod = u * longint'(TABLE_SEGMENTS);
    k    = prod / span;
    r    = prod % span;
    return knot_q24[k] + ((knot_q24[k+1] - knot_q24[k]) * r) / span;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] activate(input logic [DATA_WIDTH-1:0] raw,
                                                     input logic [MODE_W-1:0]     fn,
                                                     input logic [SLOPE_W-1:0]    slope);
    longint      x, y, hi, lo, half;
    int unsigned sh;
    sh   = SIG_Q - FRAC_BITS;
    half = longint'(1) << (sh - 1);
    hi   = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    lo   = -hi - 1;
    x    = longint'($signed(raw));
    case (fn)
      MODE_TANH:    y = (2 * sigmoid_at(2 * x) - Q_ONE + half) >>> sh;
      MODE_RELU:    y = (x > 0) ? x : 0;
      MODE_SIGMOID: y = (sigmoid_at(x) + half) >>> sh;
      MODE_LINEAR:  y = x;
      MODE_LEAKY:   y = (x < 0) ? ((x * longint'({48'd0, slope})) >>> 16) : x;
      default:      y = 0;
    endcase
    if (y > hi) y = hi;
    if (y < lo) y = lo;
    return y[DATA_WIDTH-1:0];
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    for (int k = 0; k <= TABLE_SEGMENTS; k++) knot_q24[k] = knot_value(k);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      due_q.delete();
      mode_q        <= MODE_RESET;
      slope_q       <= SLOPE_RESET;
      outstanding   <= 0;
      fail_count    = 0;
      checked_count = 0;
    end else begin
      // retire the oldest prediction first, then queue the new one
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result y=%h last=%b", m_axis_tdata, m_axis_tlast));
        end else begin
          want = due_q.pop_front();
          checked_count++;
          if (m_axis_tdata !== want.y)
            flag_mismatch($sformatf("result %0d y=%h, predicted %h",
                                    checked_count, m_axis_tdata, want.y));
          if (m_axis_tlast !== want.last)
            flag_mismatch($sformatf("result %0d last=%b, predicted %b",
                                    checked_count, m_axis_tlast, want.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        due_q.push_back('{y: activate(s_axis_tdata, mode_q, slope_q), last: s_axis_tlast});
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_MODE) mode_q <= cfg_data_i[MODE_W-1:0];
        else if (cfg_index_i == REG_LEAK_SLOPE) slope_q <= cfg_data_i[SLOPE_W-1:0];
      end
      outstanding <= due_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Stimulus and verdict for the activation unit, with the scoreboard alongside.
module testbench
  import nnact_pkg::*;
();

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RANDOM_ELEMS = 1400;

  // mode codes the unit leaves unused, and register indexes past the map
  localparam logic [MODE_W-1:0]    MODE_SPARE_LO  = MODE_W'(5);
  localparam logic [MODE_W-1:0]    MODE_SPARE_MID = MODE_W'(6);
  localparam logic [MODE_W-1:0]    MODE_SPARE_HI  = MODE_W'(7);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI   = CFG_IDX_W'(3);

  // receiver behaviors: always ready, coin flip, fixed comb, mostly stalled
  typedef enum {RX_OPEN, RX_COIN, RX_COMB, RX_STARVED} rx_style_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [DATA_WIDTH-1:0] s_axis_tdata  = '0;   // [15:0] x_in
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DATA_WIDTH-1:0] m_axis_tdata;         // [15:0] y_out
  logic                  m_axis_tlast;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  int fails;
  int outstanding;
  int checked;

  int          elems_sent  = 0;
  int          writes_done = 0;
  int          burst_left  = 0;
  int          vec_left    = 0;
  rx_style_e   rx_style    = RX_OPEN;
  int unsigned rx_left     = 0;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  nn_activation_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  nnact_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count    (fails),
    .outstanding   (outstanding),
    .checked_count (checked)
  );

  // Receiver: switch behavior after each random-length run so that stalls land
  // on every pipeline phase, with open stretches in between.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_style = rx_style_e'($urandom_range(0, 3));
      rx_left  = $urandom_range(16, 160);
    end
    rx_left--;
    case (rx_style)
      RX_OPEN:  m_axis_tready <= 1'b1;
      RX_COIN:  m_axis_tready <= ($urandom_range(0, 1) == 0);
      RX_COMB:  m_axis_tready <= (rx_left % 3 != 0);
      default:  m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Present one element and hold it until the slave transaction completes.
  // Keep tvalid high inside a burst; at the end of a burst drop it for a random
  // gap so it is never lowered and raised in the same step.
  task automatic push_sample(input int x, input bit lst);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_WIDTH'(x);
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    elems_sent++;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Drop tvalid if the last burst left it high.
  task automatic close_burst();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
  endtask

  // Hold the sender until every predicted result has come out.
  task automatic wait_idle();
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    close_burst();
    wait_idle();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    writes_done++;
  endtask

  // Fill the bits above the mode field with noise; the unit must ignore them.
  task automatic set_mode(input logic [MODE_W-1:0] m);
    write_reg(REG_MODE, {(CFG_DATA_W - MODE_W)'($urandom()), m});
  endtask

  task automatic set_slope(input logic [SLOPE_W-1:0] s);
    write_reg(REG_LEAK_SLOPE, CFG_DATA_W'(s));
  endtask

  // Mix full-range values with the interpolation window, the clamp edges of
  // sigmoid and tanh, and the extremes of the field.
  function automatic int pick_x();
    int cls, base;
    cls = $urandom_range(0, 9);
    if (cls <= 3) return int'($urandom_range(0, 65535)) - 32768;
    if (cls <= 6) return int'($urandom_range(0, 4800)) - 2400;
    if (cls == 7) return int'($urandom_range(0, 2400)) - 1200;
    if (cls == 8) begin
      case ($urandom_range(0, 4))
        0:       base = -2048;
        1:       base = 2048;
        2:       base = -1024;
        3:       base = 1024;
        default: base = 0;
      endcase
      return base + int'($urandom_range(0, 6)) - 3;
    end
    case ($urandom_range(0, 3))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  initial begin
    int r, n;
    logic [MODE_W-1:0] m;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset register values first (relu, then leaky with the
    // reset slope), then both clamp edges of sigmoid and tanh, the field
    // extremes, slope extremes, unused mode codes and writes past the map.
    push_sample(0, 1'b0);
    push_sample(1, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(32767, 1'b0);
    push_sample(-32768, 1'b1);
    settle();
    set_mode(MODE_LEAKY);
    push_sample(-32768, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(32767, 1'b1);
    settle();
    set_mode(MODE_SIGMOID);
    push_sample(-2049, 1'b0);
    push_sample(-2048, 1'b0);
    push_sample(2047, 1'b0);
    push_sample(2048, 1'b0);
    push_sample(0, 1'b1);
    settle();
    set_mode(MODE_TANH);
    push_sample(-1025, 1'b0);
    push_sample(-1024, 1'b0);
    push_sample(1023, 1'b0);
    push_sample(1024, 1'b0);
    push_sample(-32768, 1'b1);
    settle();
    set_mode(MODE_LINEAR);
    push_sample(-32768, 1'b0);
    push_sample(32767, 1'b1);
    settle();
    set_mode(MODE_LEAKY);
    set_slope(16'hFFFF);
    push_sample(-32768, 1'b0);
    push_sample(-1, 1'b1);
    settle();
    set_slope('0);
    push_sample(-5, 1'b1);
    settle();
    set_mode(MODE_SPARE_LO);
    push_sample(100, 1'b0);
    settle();
    set_mode(MODE_SPARE_MID);
    push_sample(-100, 1'b1);
    settle();
    set_mode(MODE_SPARE_HI);
    push_sample(32767, 1'b0);
    settle();
    // writes past the map must leave linear mode in place
    set_mode(MODE_LINEAR);
    write_reg(REG_SPARE_LO, '0);
    write_reg(REG_SPARE_HI, '1);
    push_sample(-300, 1'b1);

    // Random: phases of well-formed layer vectors, each under a fresh setting.
    while (elems_sent < RANDOM_ELEMS + 27) begin
      settle();
      r = $urandom_range(0, 19);
      m = (r < 18) ? MODE_W'(r % 5) : MODE_W'(MODE_SPARE_LO + MODE_W'(r % 3));
      set_mode(m);
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0:       set_slope('0);
          1:       set_slope('1);
          default: set_slope(SLOPE_W'($urandom()));
        endcase
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
                  CFG_DATA_W'($urandom()));
      n = $urandom_range(40, 140);
      for (int i = 0; i < n && elems_sent < RANDOM_ELEMS + 27; i++) begin
        if (vec_left == 0)
          vec_left = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 32);
        push_sample(pick_x(), vec_left == 1);
        vec_left--;
        // now and then drain the pipe completely mid-phase
        if ($urandom_range(0, 149) == 0) settle();
      end
    end

    settle();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d elements across %0d register writes: all five functions, clamp edges,",
             elems_sent, writes_done);
    $display("slope extremes, unused mode codes and indexes; %0d results compared.", checked);
    if (fails == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal completion.
  initial begin
    #(CLK_HALF * 2 * 400_000);
    $display("Timed out: %0d results still due", outstanding);
    $display("== FAIL ==");
    $finish;
  end

endmodule
